@@ rtl/core/framebuffer_dirty_rectangle_tracker_macros.svh @@
// Assertion macros for the framebuffer dirty rectangle tracker.
// Used by the modules under rtl/core; expects clk and rst_n in scope.
`ifndef FRAMEBUFFER_DIRTY_RECTANGLE_TRACKER_MACROS_SVH
`define FRAMEBUFFER_DIRTY_RECTANGLE_TRACKER_MACROS_SVH

// same-cycle implication
`define FBDR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBDR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fbdr_pkg.sv @@
// Shared types and constants for the framebuffer dirty rectangle tracker.
// No dependencies; used by fbdr_div and the top level.
package fbdr_pkg;

    localparam int DIV_DW = 36;
    localparam int DIV_VW = 13;
    localparam int DIV_SW = 6;

    localparam logic [DIV_SW-1:0] STEPS_LONG  = 6'd36;
    localparam logic [DIV_SW-1:0] STEPS_SHORT = 6'd7;
    localparam int CNT8_W = 7;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_END    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DEPTH  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LINE_W = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SCR_W  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SCR_H  = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BOX   = 2'd1;
    localparam logic [1:0] KIND_WHOLE = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_SW-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/fbdr_div.sv @@
// Bit-serial restoring divider shared by all divisions of the tracker's offset arithmetic.
// Depends on fbdr_pkg and the assertion macro header.
`include "framebuffer_dirty_rectangle_tracker_macros.svh"

module fbdr_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fbdr_pkg::div_ctrl_t              ctrl,
    input  logic [fbdr_pkg::DIV_DW-1:0]      dividend,
    input  logic [fbdr_pkg::DIV_VW-1:0]      divisor,
    output fbdr_pkg::div_stat_t              stat,
    output logic [fbdr_pkg::DIV_DW-1:0]      quotient,
    output logic [fbdr_pkg::DIV_VW-1:0]      remainder
);

    logic [fbdr_pkg::DIV_DW-1:0] num_reg, num_next;
    logic [fbdr_pkg::DIV_VW-1:0] rem_reg, rem_next;
    logic [fbdr_pkg::DIV_VW-1:0] dvs_reg, dvs_next;
    logic [fbdr_pkg::DIV_SW-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [fbdr_pkg::DIV_VW:0]   shifted;
    logic [fbdr_pkg::DIV_VW:0]   diff;
    logic                        ge;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[fbdr_pkg::DIV_DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = ctrl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[fbdr_pkg::DIV_DW-2:0], ge};
            rem_next = ge ? diff[fbdr_pkg::DIV_VW-1:0] : shifted[fbdr_pkg::DIV_VW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fbdr_pkg::DIV_SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

    `FBDR_CHECK(a_done_after_busy, done_reg, $past(busy_reg), "divider done without run")
    `FBDR_CHECK(a_busy_count, busy_reg, cnt_reg != '0, "divider busy with zero count")
    `FBDR_CHECK(a_rem_below, done_reg && dvs_reg != '0, rem_reg < dvs_reg, "remainder too large")

endmodule

@@ rtl/core/framebuffer_dirty_rectangle_tracker.sv @@
// Top level of the framebuffer dirty rectangle tracker: config, sequencer, box.
// Depends on fbdr_pkg, fbdr_div and the assertion macro header.
//
//   channel  direction  handshake              word
//   in       sink       in_valid / in_stall    op, address, byte_count
//   out      source     out_valid / out_stall  region_kind, rect_x/y/width/height
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// A write inside the region holds in_stall after it is accepted while it runs three 36-step
// and one 7-step division on the single shared bit-serial divider, one bit per cycle.
// A drain or a write outside the region does not use the divider.
// in_stall is high while a write is in the divider, and while a result waits stalled.
// Reset gives an empty box with the whole-screen flag set and default geometry.
`include "framebuffer_dirty_rectangle_tracker_macros.svh"

module framebuffer_dirty_rectangle_tracker
#(
    parameter int  MAX_DIMENSION = 4096,
    localparam int CW            = $clog2(MAX_DIMENSION)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbdr_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [fbdr_pkg::CFG_DW-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [31:0]                       address,
    input  logic [3:0]                        byte_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        region_kind,
    output logic [CW-1:0]                     rect_x,
    output logic [CW-1:0]                     rect_y,
    output logic [CW:0]                       rect_width,
    output logic [CW:0]                       rect_height
);

    localparam int DW = fbdr_pkg::DIV_DW;
    localparam int VW = fbdr_pkg::DIV_VW;
    localparam int SW = (CW > VW) ? CW : VW;
    localparam logic [CW-1:0] COORD_MAX = CW'(MAX_DIMENSION - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_O1,
        S_K,
        S_Y1,
        S_Y2
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]    base_reg, base_next;
    logic [31:0]    end_reg, end_next;
    logic [5:0]     depth_reg, depth_next;
    logic [VW-1:0]  linew_reg, linew_next;
    logic [VW-1:0]  scrw_reg, scrw_next;
    logic [VW-1:0]  scrh_reg, scrh_next;

    logic           empty_reg, empty_next;
    logic           whole_reg, whole_next;
    logic [CW-1:0]  left_reg, left_next;
    logic [CW-1:0]  top_reg, top_next;
    logic [CW-1:0]  right_reg, right_next;
    logic [CW-1:0]  bottom_reg, bottom_next;

    logic [3:0]     cnt_reg, cnt_next;
    logic [DW-1:0]  o1_reg, o1_next;
    logic [DW-1:0]  o2_reg, o2_next;
    logic [CW-1:0]  x1_reg, x1_next;
    logic [CW-1:0]  y1_reg, y1_next;

    logic                        start_reg, start_next;
    logic [DW-1:0]               dvd_reg, dvd_next;
    logic [VW-1:0]               dvs_reg, dvs_next;
    logic [fbdr_pkg::DIV_SW-1:0] steps_reg, steps_next;

    logic           ovalid_reg, ovalid_next;
    logic [1:0]     kind_reg, kind_next;
    logic [CW-1:0]  ox_reg, ox_next;
    logic [CW-1:0]  oy_reg, oy_next;
    logic [CW:0]    ow_reg, ow_next;
    logic [CW:0]    oh_reg, oh_next;

    fbdr_pkg::div_ctrl_t div_ctrl;
    fbdr_pkg::div_stat_t div_stat;
    logic [DW-1:0]       div_q;
    logic [VW-1:0]       div_r;

    logic [5:0]     depth_eff;
    logic [VW-1:0]  linew_eff;
    logic [VW-1:0]  hm1;
    logic [31:0]    diff;
    logic           accept;
    logic           out_take;
    logic [CW-1:0]  x2, y2, l, r, t, b;

    function automatic logic [CW-1:0] sat_coord(input logic [VW-1:0] v);
        logic [SW-1:0] wide;
        begin
            wide = SW'(v);
            if (wide > SW'(COORD_MAX))
                sat_coord = COORD_MAX;
            else
                sat_coord = CW'(wide);
        end
    endfunction

    function automatic logic [CW-1:0] clamp_y(input logic [DW-1:0] q,
                                              input logic [VW-1:0] lim);
        logic [VW-1:0] yy;
        begin
            yy = (q > DW'(lim)) ? lim : q[VW-1:0];
            clamp_y = sat_coord(yy);
        end
    endfunction

    fbdr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign div_ctrl.start = start_reg;
    assign div_ctrl.steps = steps_reg;

    assign depth_eff = (depth_reg == '0) ? 6'd1 : depth_reg;
    assign linew_eff = (linew_reg == '0) ? VW'(1) : linew_reg;
    assign hm1       = (scrh_reg == '0) ? '0 : scrh_reg - VW'(1);
    assign diff      = address - base_reg;

    assign out_take  = ovalid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (ovalid_reg && out_stall);
    assign accept    = in_valid && !in_stall;

    assign x2 = sat_coord(div_r);
    assign y2 = clamp_y(div_q, hm1);

    always_comb
    begin
        l = (x1_reg < x2) ? x1_reg : x2;
        r = (x1_reg < x2) ? x2 : x1_reg;
        t = (y1_reg < y2) ? y1_reg : y2;
        b = (y1_reg < y2) ? y2 : y1_reg;
        if (!empty_reg)
        begin
            if (left_reg < l)
                l = left_reg;
            if (top_reg < t)
                t = top_reg;
            if (right_reg > r)
                r = right_reg;
            if (bottom_reg > b)
                b = bottom_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        end_next    = end_reg;
        depth_next  = depth_reg;
        linew_next  = linew_reg;
        scrw_next   = scrw_reg;
        scrh_next   = scrh_reg;
        empty_next  = empty_reg;
        whole_next  = whole_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        cnt_next    = cnt_reg;
        o1_next     = o1_reg;
        o2_next     = o2_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        start_next  = 1'b0;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        steps_next  = steps_reg;
        ovalid_next = out_take ? 1'b0 : ovalid_reg;
        kind_next   = kind_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ow_next     = ow_reg;
        oh_next     = oh_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                fbdr_pkg::REG_BASE:   base_next  = cfg_data;
                fbdr_pkg::REG_END:    end_next   = cfg_data;
                fbdr_pkg::REG_DEPTH:  depth_next = cfg_data[5:0];
                fbdr_pkg::REG_LINE_W: linew_next = cfg_data[VW-1:0];
                fbdr_pkg::REG_SCR_W:  scrw_next  = cfg_data[VW-1:0];
                fbdr_pkg::REG_SCR_H:  scrh_next  = cfg_data[VW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == fbdr_pkg::OP_DRAIN)
                begin
                    ovalid_next = 1'b1;
                    if (whole_reg)
                    begin
                        kind_next = fbdr_pkg::KIND_WHOLE;
                        ox_next   = '0;
                        oy_next   = '0;
                        ow_next   = (CW+1)'(scrw_reg);
                        oh_next   = (CW+1)'(scrh_reg);
                    end
                    else if (empty_reg)
                    begin
                        kind_next = fbdr_pkg::KIND_NONE;
                        ox_next   = '0;
                        oy_next   = '0;
                        ow_next   = '0;
                        oh_next   = '0;
                    end
                    else
                    begin
                        kind_next   = fbdr_pkg::KIND_BOX;
                        ox_next     = left_reg;
                        oy_next     = top_reg;
                        ow_next     = {1'b0, right_reg} - {1'b0, left_reg} + 1'b1;
                        oh_next     = {1'b0, bottom_reg} - {1'b0, top_reg} + 1'b1;
                        empty_next  = 1'b1;
                        left_next   = '0;
                        top_next    = '0;
                        right_next  = '0;
                        bottom_next = '0;
                    end
                end
                else if (accept && address >= base_reg && address <= end_reg)
                begin
                    cnt_next   = byte_count;
                    start_next = 1'b1;
                    dvd_next   = DW'({diff, 3'b000});
                    dvs_next   = VW'(depth_eff);
                    steps_next = fbdr_pkg::STEPS_LONG;
                    state_next = S_O1;
                end
            end
            S_O1:
            begin
                if (div_stat.done)
                begin
                    o1_next    = div_q;
                    start_next = 1'b1;
                    dvd_next   = {cnt_reg, 3'b000, (DW - fbdr_pkg::CNT8_W)'(0)};
                    steps_next = fbdr_pkg::STEPS_SHORT;
                    state_next = S_K;
                end
            end
            S_K:
            begin
                if (div_stat.done)
                begin
                    o2_next    = o1_reg + DW'(div_q[fbdr_pkg::CNT8_W-1:0]);
                    start_next = 1'b1;
                    dvd_next   = o1_reg;
                    dvs_next   = linew_eff;
                    steps_next = fbdr_pkg::STEPS_LONG;
                    state_next = S_Y1;
                end
            end
            S_Y1:
            begin
                if (div_stat.done)
                begin
                    x1_next    = x2;
                    y1_next    = y2;
                    start_next = 1'b1;
                    dvd_next   = o2_reg;
                    state_next = S_Y2;
                end
            end
            S_Y2:
            begin
                if (div_stat.done)
                begin
                    left_next   = l;
                    right_next  = r;
                    top_next    = t;
                    bottom_next = b;
                    empty_next  = 1'b0;
                    whole_next  = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            end_reg    <= '0;
            depth_reg  <= 6'd16;
            linew_reg  <= VW'(640);
            scrw_reg   <= VW'(640);
            scrh_reg   <= VW'(480);
            empty_reg  <= 1'b1;
            whole_reg  <= 1'b1;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            start_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            end_reg    <= end_next;
            depth_reg  <= depth_next;
            linew_reg  <= linew_next;
            scrw_reg   <= scrw_next;
            scrh_reg   <= scrh_next;
            empty_reg  <= empty_next;
            whole_reg  <= whole_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            start_reg  <= start_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        o1_reg    <= o1_next;
        o2_reg    <= o2_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        steps_reg <= steps_next;
        kind_reg  <= kind_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ow_reg    <= ow_next;
        oh_reg    <= oh_next;
    end

    assign out_valid   = ovalid_reg;
    assign region_kind = kind_reg;
    assign rect_x      = ox_reg;
    assign rect_y      = oy_reg;
    assign rect_width  = ow_reg;
    assign rect_height = oh_reg;

    `FBDR_CHECK(a_out_from_drain, $rose(ovalid_reg),
        $past(in_valid && !in_stall && op == fbdr_pkg::OP_DRAIN), "result without drain")
    `FBDR_CHECK(a_box_ordered, !empty_reg,
        left_reg <= right_reg && top_reg <= bottom_reg, "dirty box inverted")
    `FBDR_CHECK(a_empty_zero, empty_reg,
        left_reg == '0 && top_reg == '0 && right_reg == '0 && bottom_reg == '0,
        "empty box not cleared")
    `FBDR_CHECK(a_div_idle_start, start_reg, !div_stat.busy, "divider restarted while busy")

endmodule

@@ test/tb_framebuffer_dirty_rectangle_tracker.sv @@
// Self-checking testbench for framebuffer_dirty_rectangle_tracker: snooped writes and
// drain requests under random gaps and stalls, checked against a behavioural predictor.
// Depends on fbdr_pkg and the RTL of the tracker only.
module tb_framebuffer_dirty_rectangle_tracker;

    localparam int MAX_DIMENSION = 4096;
    localparam int CW = 12;
    localparam logic [63:0] COORD_MAX = 64'(MAX_DIMENSION - 1);
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic        op;
        logic [31:0] addr;
        logic [3:0]  cnt;
        bit          hold_back;
    } bus_word_t;

    typedef struct {
        logic [1:0]    kind;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW:0]   w;
        logic [CW:0]   h;
    } region_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [fbdr_pkg::CFG_IW-1:0] cfg_index = fbdr_pkg::REG_BASE;
    logic [fbdr_pkg::CFG_DW-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        op = fbdr_pkg::OP_WRITE;
    logic [31:0]                 address = '0;
    logic [3:0]                  byte_count = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [1:0]                  region_kind;
    logic [CW-1:0]               rect_x;
    logic [CW-1:0]               rect_y;
    logic [CW:0]                 rect_width;
    logic [CW:0]                 rect_height;

    // register shadow, at reset values
    logic [31:0] base_q = '0;
    logic [31:0] end_q = '0;
    logic [5:0]  depth_q = 6'd16;
    logic [12:0] line_w_q = 13'd640;
    logic [12:0] scr_w_q = 13'd640;
    logic [12:0] scr_h_q = 13'd480;

    // tracked box, at reset values
    bit            box_empty_q = 1'b1;
    bit            whole_q = 1'b1;
    logic [CW-1:0] left_q = '0;
    logic [CW-1:0] top_q = '0;
    logic [CW-1:0] right_q = '0;
    logic [CW-1:0] bottom_q = '0;

    bus_word_t   pending_words[$];
    region_t     due_regions[$];
    bus_word_t   next_word;
    int unsigned words_pushed = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned stall_run = 0;
    int unsigned free_run = 0;
    bit          word_taken = 1'b0;
    bit          quiet = 1'b0;

    framebuffer_dirty_rectangle_tracker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .address     (address),
        .byte_count  (byte_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .region_kind (region_kind),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 8);
    endfunction

    function automatic void offset_to_point(input logic [63:0] off,
                                            output logic [CW-1:0] px,
                                            output logic [CW-1:0] py);
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] xx;
        logic [63:0] yy;
        w = (line_w_q == 0) ? 64'd1 : {51'd0, line_w_q};
        h = (scr_h_q == 0) ? 64'd1 : {51'd0, scr_h_q};
        xx = off % w;
        yy = off / w;
        if (yy > h - 64'd1)
            yy = h - 64'd1;
        px = (xx > COORD_MAX) ? COORD_MAX[CW-1:0] : xx[CW-1:0];
        py = (yy > COORD_MAX) ? COORD_MAX[CW-1:0] : yy[CW-1:0];
    endfunction

    function automatic void track_word(input bus_word_t wd);
        logic [63:0]   d;
        logic [63:0]   o1;
        logic [63:0]   o2;
        logic [31:0]   rel;
        logic [CW-1:0] x1, y1, x2, y2, l, t, r, b;
        region_t       res;
        if (wd.op == fbdr_pkg::OP_WRITE)
        begin
            if (wd.addr < base_q || wd.addr > end_q)
                return;
            d = (depth_q == 0) ? 64'd1 : {58'd0, depth_q};
            rel = wd.addr - base_q;
            o1 = ({32'd0, rel} * 64'd8) / d;
            o2 = o1 + ({60'd0, wd.cnt} * 64'd8) / d;
            offset_to_point(o1, x1, y1);
            offset_to_point(o2, x2, y2);
            l = (x1 < x2) ? x1 : x2;
            r = (x1 < x2) ? x2 : x1;
            t = (y1 < y2) ? y1 : y2;
            b = (y1 < y2) ? y2 : y1;
            if (!box_empty_q)
            begin
                if (left_q < l)
                    l = left_q;
                if (top_q < t)
                    t = top_q;
                if (right_q > r)
                    r = right_q;
                if (bottom_q > b)
                    b = bottom_q;
            end
            left_q = l;
            top_q = t;
            right_q = r;
            bottom_q = b;
            box_empty_q = 1'b0;
            whole_q = 1'b0;
            return;
        end
        res.kind = fbdr_pkg::KIND_NONE;
        res.x = '0;
        res.y = '0;
        res.w = '0;
        res.h = '0;
        if (whole_q)
        begin
            res.kind = fbdr_pkg::KIND_WHOLE;
            res.w = scr_w_q;
            res.h = scr_h_q;
        end
        else if (!box_empty_q)
        begin
            res.kind = fbdr_pkg::KIND_BOX;
            res.x = left_q;
            res.y = top_q;
            res.w = {1'b0, right_q} - {1'b0, left_q} + 1'b1;
            res.h = {1'b0, bottom_q} - {1'b0, top_q} + 1'b1;
            box_empty_q = 1'b1;
            left_q = '0;
            top_q = '0;
            right_q = '0;
            bottom_q = '0;
        end
        due_regions.push_back(res);
    endfunction

    function automatic void check_region();
        region_t want;
        if (due_regions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected region kind=%0d x=%0d y=%0d w=%0d h=%0d",
                         $realtime, region_kind, rect_x, rect_y, rect_width, rect_height);
            return;
        end
        want = due_regions.pop_front();
        if (want.kind !== region_kind || want.x !== rect_x || want.y !== rect_y ||
            want.w !== rect_width || want.h !== rect_height)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: region expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                         $realtime, want.kind, want.x, want.y, want.w, want.h,
                         region_kind, rect_x, rect_y, rect_width, rect_height);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                next_word.op = op;
                next_word.addr = address;
                next_word.cnt = byte_count;
                next_word.hold_back = 1'b0;
                track_word(next_word);
                words_taken++;
            end
            if (out_valid && !out_stall)
                check_region();
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || word_taken)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_words.size() != 0 &&
                     !(pending_words[0].hold_back && due_regions.size() != 0))
            begin
                next_word = pending_words.pop_front();
                op <= next_word.op;
                address <= next_word.addr;
                byte_count <= next_word.cnt;
                in_valid <= 1'b1;
                send_gap = quiet ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else if (free_run != 0)
        begin
            out_stall <= 1'b0;
            free_run--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run = quiet ? 0 : pick_gap();
            free_run = pick_gap();
        end
    end

    task automatic queue_word(input logic wop, input logic [31:0] waddr,
                              input logic [3:0] wcnt, input bit hold = 1'b0);
        bus_word_t wd;
        wd.op = wop;
        wd.addr = waddr;
        wd.cnt = wcnt;
        wd.hold_back = hold;
        pending_words.push_back(wd);
        words_pushed++;
    endtask

    task automatic set_reg(input logic [fbdr_pkg::CFG_IW-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            fbdr_pkg::REG_BASE:   base_q = val;
            fbdr_pkg::REG_END:    end_q = val;
            fbdr_pkg::REG_DEPTH:  depth_q = val[5:0];
            fbdr_pkg::REG_LINE_W: line_w_q = val[12:0];
            fbdr_pkg::REG_SCR_W:  scr_w_q = val[12:0];
            fbdr_pkg::REG_SCR_H:  scr_h_q = val[12:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] rbase, input logic [31:0] rend,
                                input int unsigned depth, input int unsigned lw,
                                input int unsigned sw, input int unsigned sh);
        set_reg(fbdr_pkg::REG_BASE, rbase);
        set_reg(fbdr_pkg::REG_END, rend);
        set_reg(fbdr_pkg::REG_DEPTH, depth);
        set_reg(fbdr_pkg::REG_LINE_W, lw);
        set_reg(fbdr_pkg::REG_SCR_W, sw);
        set_reg(fbdr_pkg::REG_SCR_H, sh);
    endtask

    // wait for every word and result, then let any write still in the divider finish
    task automatic settle();
        @(negedge clk);
        while (words_taken != words_pushed || due_regions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(input int unsigned count, input bit pauses);
        int unsigned depth, lw, sw, sh, r;
        logic [31:0] rbase, rend, a;
        logic [63:0] size, lim, span, off;
        r = $urandom_range(9);
        if (r < 7)
        begin
            case ($urandom_range(7))
                0: depth = 1;
                1: depth = 2;
                2: depth = 4;
                3: depth = 8;
                4: depth = 12;
                5: depth = 16;
                6: depth = 24;
                default: depth = 32;
            endcase
        end
        else
            depth = $urandom_range(32, 1);
        case ($urandom_range(3))
            0: lw = $urandom_range(16, 1);
            1: lw = $urandom_range(640, 17);
            2: lw = $urandom_range(4096, 641);
            default: lw = 4096;
        endcase
        sh = ($urandom_range(1) != 0) ? $urandom_range(32, 1) : $urandom_range(4096, 1);
        sw = $urandom_range(4096, 1);
        rbase = $urandom;
        size = {32'd0, lw} * {32'd0, sh} * {32'd0, depth} / 64'd8;
        if (size == 0)
            size = 1;
        lim = {32'd0, rbase} + size - 64'd1;
        if (lim > 64'hFFFF_FFFF)
            lim = 64'hFFFF_FFFF;
        r = $urandom_range(11);
        if (r == 0)
            rend = 32'hFFFF_FFFF;
        else if (r == 1 && rbase != 0)
            rend = rbase - 1;
        else
            rend = lim[31:0];
        set_geometry(rbase, rend, depth, lw, sw, sh);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(5) == 0)
            begin
                queue_word(fbdr_pkg::OP_DRAIN, $urandom, 4'($urandom_range(15)),
                           pauses && (i % 12 == 11));
                continue;
            end
            r = $urandom_range(99);
            if (r < 75 && rend >= rbase)
            begin
                span = {32'd0, rend} - {32'd0, rbase} + 64'd1;
                if ($urandom_range(3) == 0)
                    off = {56'd0, 8'($urandom_range(255))} % span;
                else
                    off = {$urandom, $urandom} % span;
                a = rbase + off[31:0];
            end
            else if (r < 88)
            begin
                case ($urandom_range(3))
                    0: a = rbase - 1;
                    1: a = rend + 1;
                    2: a = rbase;
                    default: a = rend;
                endcase
            end
            else
                a = $urandom;
            queue_word(fbdr_pkg::OP_WRITE, a, 4'($urandom_range(8)),
                       pauses && (i % 12 == 11));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: region is the single byte at address zero
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_DRAIN, 32'hFFFF_FFFF, 4'd15);
        queue_word(fbdr_pkg::OP_WRITE, 32'h1, 4'd8);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_WRITE, 32'h0, 4'd8);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_WRITE, 32'hFFFF_FFFF, 4'd8);
        settle();

        set_geometry(32'hFFFF_F000, 32'hFFFF_FFFF, 1, 1, 4096, 4096);
        queue_word(fbdr_pkg::OP_WRITE, 32'hFFFF_FFFF, 4'd8);
        queue_word(fbdr_pkg::OP_WRITE, 32'hFFFF_F000, 4'd0);
        queue_word(fbdr_pkg::OP_WRITE, 32'hFFFF_EFFF, 4'd8);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        settle();

        set_geometry(32'h0, 32'hFFFF_FFFF, 32, 4096, 1, 1);
        queue_word(fbdr_pkg::OP_WRITE, 32'hFFFF_FFFC, 4'd8);
        queue_word(fbdr_pkg::OP_WRITE, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_WRITE, 32'h10, 4'd3);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        settle();

        set_geometry(32'h100, 32'h1FF, 3, 5, 9, 7);
        queue_word(fbdr_pkg::OP_WRITE, 32'h100, 4'd7);
        queue_word(fbdr_pkg::OP_WRITE, 32'h1FF, 4'd1);
        queue_word(fbdr_pkg::OP_DRAIN, 32'h0, 4'd0);
        settle();

        for (int unsigned p = 0; p < 6; p++)
        begin
            quiet = (p == 2);
            run_random_phase(72, p == 4);
            settle();
        end

        if (mismatches == 0 && due_regions.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
